>>> sv/csq_pkg.sv
// shared types, constants and register map of the checkweigher stability qualifier
// no dependencies; imported by every module of the block
package csq_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int STD_W       = 20;
  localparam int TOL_W       = 17;
  localparam int BAND_W      = 17;
  localparam int REQ_W       = 8;
  localparam int ALPHA_W     = 17;
  localparam int RATIO_W     = 17;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int ACC_W       = 40;
  localparam int FRAC_W      = 16;
  localparam int THR_W       = STD_W + RATIO_W;
  localparam int LIMIT_W     = STD_W + 2;

  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [REQ_W-1:0]   COUNT_MAX = '1;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_STANDARD_WEIGHT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_BAND     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_REQUIRED = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_Q16       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_RATIO_Q16 = 3'd5;

  localparam logic [STD_W-1:0]   STD_RST   = STD_W'(0);
  localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(500);
  localparam logic [BAND_W-1:0]  BAND_RST  = BAND_W'(100);
  localparam logic [REQ_W-1:0]   REQ_RST   = REQ_W'(30);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(13107);
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(6554);

  typedef enum logic {
    OP_HOLD,
    OP_UPDATE
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_OK   = 2'd1,
    VERDICT_NG   = 2'd2
  } verdict_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [STD_W-1:0]   standard_weight;
    logic [TOL_W-1:0]   tolerance;
    logic [BAND_W-1:0]  stable_band;
    logic [REQ_W-1:0]   stable_required;
    logic [ALPHA_W-1:0] alpha_q16;
    logic [RATIO_W-1:0] empty_ratio_q16;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_weight;
    logic                       is_stable;
    verdict_t                   verdict;
    logic                       beep_ok;
    logic                       beep_ng;
  } result_t;

endpackage

>>> sv/csq_front.sv
// front end: accepts input words, tags each as filter update or timeout hold
// depends on csq_pkg; feeds csq_fifo
module csq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [csq_pkg::SAMPLE_W-1:0] sample,
  input  logic                                sample_ready,
  output logic                                push,
  output csq_pkg::item_t                      push_item,
  input  logic                                full
);
  import csq_pkg::*;

  logic  front_valid;
  item_t front_item;
  logic  in_accept;

  assign push      = front_valid && !full;
  assign in_ready  = !front_valid || !full;
  assign in_accept = in_valid && in_ready;
  assign push_item = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      front_item.op     <= sample_ready ? OP_UPDATE : OP_HOLD;
      front_item.sample <= sample;
    end
  end

endmodule

>>> sv/csq_fifo.sv
// short word queue between front end and filter back end
// depends on csq_pkg for the queued word type
module csq_fifo #(
  parameter int DEPTH = csq_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csq_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output csq_pkg::item_t pop_item,
  output logic           not_empty
);
  import csq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

>>> sv/csq_back.sv
// back end: exponential filter stage, then stability count and verdict into output register
// depends on csq_pkg; pops words from csq_fifo
module csq_back (
  input  logic             clk,
  input  logic             rst,
  input  csq_pkg::cfg_t    cfg,
  input  logic             not_empty,
  input  csq_pkg::item_t   pop_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output csq_pkg::result_t res
);
  import csq_pkg::*;

  localparam int DIFF_W = ACC_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int STEP_W = SAMPLE_W + 1;
  localparam int CMP_W  = SAMPLE_W + 2;
  localparam int EMP_W  = SAMPLE_W - 1 + FRAC_W;

  // filter state and stage one
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic [ALPHA_W-1:0]         alpha_sat;
  logic signed [ACC_W-1:0]    x;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_f;

  // decision state
  logic signed [SAMPLE_W-1:0] prev;
  logic [REQ_W-1:0]           count;
  logic [REQ_W-1:0]           count_next;
  verdict_t                   verdict_q;
  verdict_t                   verdict_next;
  logic                       beep_ok_next;
  logic                       beep_ng_next;
  logic                       stable;

  // config-derived limits, static while words flow only if the user holds cfg; not enforced here
  logic [THR_W-1:0]           empty_thr;
  logic signed [LIMIT_W-1:0]  tol_lo;
  logic signed [LIMIT_W-1:0]  tol_hi;

  logic signed [STEP_W-1:0]   step;
  logic [STEP_W-1:0]          step_abs;
  logic                       in_band;
  logic                       is_empty;
  logic                       in_tol;
  logic signed [CMP_W-1:0]    f_w;

  logic out_advance;

  assign out_advance = s1_valid && (!out_valid || out_ready);
  assign pop         = not_empty && (!s1_valid || out_advance);

  // filter: acc += floor(a * (x - acc) / 2^16) on update words, bit slice gives the floor; hold words keep acc
  always_comb begin
    alpha_sat = (cfg.alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q16;
    x         = {pop_item.sample, {FRAC_W{1'b0}}};
    diff      = {x[ACC_W-1], x} - {acc[ACC_W-1], acc};
    prod      = $signed({1'b0, alpha_sat}) * diff;
    if (pop_item.op == OP_UPDATE) begin
      acc_next = acc + prod[FRAC_W+ACC_W-1:FRAC_W];
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (pop) begin
        acc <= acc_next;
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (out_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_f <= acc_next[ACC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    empty_thr <= cfg.standard_weight * cfg.empty_ratio_q16;
    tol_lo    <= $signed({2'b00, cfg.standard_weight})
               - $signed(LIMIT_W'(cfg.tolerance));
    tol_hi    <= $signed({2'b00, cfg.standard_weight})
               + $signed(LIMIT_W'(cfg.tolerance));
  end

  always_comb begin
    step     = {s1_f[SAMPLE_W-1], s1_f} - {prev[SAMPLE_W-1], prev};
    step_abs = step[STEP_W-1] ? STEP_W'(-step) : STEP_W'(step);
    in_band  = step_abs <= STEP_W'(cfg.stable_band);
    if (!in_band) begin
      count_next = '0;
    end else if (count == COUNT_MAX) begin
      count_next = count;
    end else begin
      count_next = count + 1'b1;
    end
    stable = count_next >= cfg.stable_required;

    // negative weight is always empty
    is_empty = s1_f[SAMPLE_W-1]
            || ({s1_f[SAMPLE_W-2:0], {FRAC_W{1'b0}}} <= EMP_W'(empty_thr));
    f_w      = CMP_W'(s1_f);
    in_tol   = (f_w >= CMP_W'(tol_lo)) && (f_w <= CMP_W'(tol_hi));

    verdict_next = verdict_q;
    beep_ok_next = 1'b0;
    beep_ng_next = 1'b0;
    priority if (!stable) begin
      verdict_next = verdict_q;
    end else if (is_empty) begin
      verdict_next = VERDICT_NONE;
    end else if (verdict_q == VERDICT_NONE) begin
      if (in_tol) begin
        verdict_next = VERDICT_OK;
        beep_ok_next = 1'b1;
      end else begin
        verdict_next = VERDICT_NG;
        beep_ng_next = 1'b1;
      end
    end else begin
      verdict_next = verdict_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      count     <= '0;
      verdict_q <= VERDICT_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_advance) begin
        prev      <= s1_f;
        count     <= count_next;
        verdict_q <= verdict_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance) begin
      res.filtered_weight <= s1_f;
      res.is_stable       <= stable;
      res.verdict         <= verdict_next;
      res.beep_ok         <= beep_ok_next;
      res.beep_ng         <= beep_ng_next;
    end
  end

  a_one_beep: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> !(res.beep_ok && res.beep_ng))
    else $error("both beeps in one word");
  a_beep_ok_verdict: assert property (@(posedge clk) disable iff (rst)
      (out_valid && res.beep_ok) |-> (res.verdict == VERDICT_OK))
    else $error("ok beep without ok verdict");
  a_beep_needs_stable: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (res.beep_ok || res.beep_ng)) |-> res.is_stable)
    else $error("beep on unstable word");
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
      out_advance |=> (res.verdict == verdict_q))
    else $error("output verdict differs from latched verdict");

endmodule

>>> sv/checkweigher_stability_qualifier.sv
// top level of the checkweigher stability qualifier: config registers, front, queue, back
// depends on csq_pkg, csq_front, csq_fifo, csq_back
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------------
//   in      | in_valid / in_ready  | sample, sample_ready
//   out     | out_valid / out_ready| filtered_weight, is_stable, verdict, beep_ok, beep_ng
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// sustained rate one word per clock while out_ready stays high; an accepted word passes through
// the front register, queue, filter stage and output register in that order.
// the filter accumulator update (one 41x18 signed multiply and add) closes the per-word loop.
// rst is synchronous: clears filter, stability count, verdict, queue and valids, and
// loads the register reset values.
// holding out_ready low fills output, filter stage, queue and front, then drops in_ready.
module checkweigher_stability_qualifier #(
  parameter int FIFO_DEPTH = csq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [csq_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [csq_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [csq_pkg::SAMPLE_W-1:0]    sample,
  input  logic                                   sample_ready,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [csq_pkg::SAMPLE_W-1:0]    filtered_weight,
  output logic                                   is_stable,
  output logic [1:0]                             verdict,
  output logic                                   beep_ok,
  output logic                                   beep_ng
);
  import csq_pkg::*;

  cfg_t    cfg;
  item_t   push_item;
  item_t   pop_item;
  result_t res;
  logic    push;
  logic    pop;
  logic    full;
  logic    not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standard_weight <= STD_RST;
      cfg.tolerance       <= TOL_RST;
      cfg.stable_band     <= BAND_RST;
      cfg.stable_required <= REQ_RST;
      cfg.alpha_q16       <= ALPHA_RST;
      cfg.empty_ratio_q16 <= RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STANDARD_WEIGHT: cfg.standard_weight <= cfg_data[STD_W-1:0];
        REG_TOLERANCE:       cfg.tolerance       <= cfg_data[TOL_W-1:0];
        REG_STABLE_BAND:     cfg.stable_band     <= cfg_data[BAND_W-1:0];
        REG_STABLE_REQUIRED: cfg.stable_required <= cfg_data[REQ_W-1:0];
        REG_ALPHA_Q16:       cfg.alpha_q16       <= cfg_data[ALPHA_W-1:0];
        REG_EMPTY_RATIO_Q16: cfg.empty_ratio_q16 <= cfg_data[RATIO_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  csq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .sample_ready (sample_ready),
    .push         (push),
    .push_item    (push_item),
    .full         (full)
  );

  csq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  csq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .not_empty (not_empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign filtered_weight = res.filtered_weight;
  assign is_stable       = res.is_stable;
  assign verdict         = res.verdict;
  assign beep_ok         = res.beep_ok;
  assign beep_ng         = res.beep_ng;

endmodule
